### rtl/core/abst_pkg.sv
package abst_pkg;

    localparam int TREE_LEVELS_DEF = 7;
    localparam int KEY_W           = 31;
    localparam int OUT_IDX_W       = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key_value;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [OUT_IDX_W-1:0]  node_index;
        logic [OUT_IDX_W-1:0]  stored_count;
    } t_rsp;

endpackage

### rtl/core/abst_ram.sv
module abst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 127
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/array_bst_insert_search_top.sv
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+---------------------------------
// request   | i_in_valid  | o_in_stall  | i_in_data  (kind, key_value)
// result    | o_out_valid | i_out_stall | o_out_data (status, node_index,
//           |             |             |             stored_count)
//
// a request is accepted, then walks the tree one level at a time (a single registered
// read port of the node ram), then hands off the result; an insert into a full tree
// skips the walk and goes straight to the hand-off.
// after reset a clearing pass writes every node slot empty, with the request side
// stalled.
// a waiting result sits in the output register; the next request may walk meanwhile
// and only its hand-off waits for the output register to drain.
module array_bst_insert_search_top
    import abst_pkg::*;
#(
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_req  i_in_data,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_rsp  o_out_data
);

    localparam int AW    = TREE_LEVELS;
    localparam int NODES = (1 << TREE_LEVELS) - 1;
    localparam int RW    = KEY_W + 1;
    localparam logic [AW:0]   NODES_W   = (AW+1)'(NODES);
    localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
    localparam logic [AW-1:0] FULL_CNT  = AW'(NODES);

    t_state            r_state, n_state;
    logic              r_kind, n_kind;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_clr, n_clr;
    t_status           r_res_st, n_res_st;
    logic [AW-1:0]     r_res_idx, n_res_idx;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic [RW-1:0]     ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [RW-1:0]     ram_rd_data;

    logic              node_used;
    logic [KEY_W-1:0]  node_val;
    logic              go_left;
    logic [AW:0]       nxt_idx;
    logic              out_free;

    abst_ram #(
        .WIDTH (RW),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ram word: occupancy bit on top of the stored key
    assign node_used = ram_rd_data[RW-1];
    assign node_val  = ram_rd_data[KEY_W-1:0];
    assign go_left   = node_val > r_key;
    assign nxt_idx   = ({1'b0, r_idx} << 1) + (go_left ? (AW+1)'(1) : (AW+1)'(2));
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_res_st  <= n_res_st;
        r_res_idx <= n_res_idx;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_idx       = r_idx;
        n_count     = r_count;
        n_clr       = r_clr;
        n_res_st    = r_res_st;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = {1'b1, r_key};
        ram_rd_addr = r_idx;
        o_in_stall  = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_clr;
                ram_wr_data = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall  = 1'b0;
                ram_rd_addr = '0;
                if (i_in_valid) begin
                    n_kind = i_in_data.kind;
                    n_key  = i_in_data.key_value;
                    n_idx  = '0;
                    if (i_in_data.kind == KIND_INSERT && r_count == FULL_CNT) begin
                        n_res_st  = ST_FULL;
                        n_res_idx = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!node_used) begin
                    if (r_kind == KIND_INSERT) begin
                        ram_we    = 1'b1;
                        n_count   = r_count + AW'(1);
                        n_res_st  = ST_INSERTED;
                        n_res_idx = r_idx;
                    end else begin
                        n_res_st  = ST_MISSING;
                        n_res_idx = '0;
                    end
                    n_state = S_DONE;
                end else if (r_kind == KIND_SEARCH && node_val == r_key) begin
                    n_res_st  = ST_FOUND;
                    n_res_idx = r_idx;
                    n_state   = S_DONE;
                end else if (nxt_idx >= NODES_W) begin
                    // walk ran off the bottom level
                    n_res_st  = (r_kind == KIND_INSERT) ? ST_FULL : ST_MISSING;
                    n_res_idx = '0;
                    n_state   = S_DONE;
                end else begin
                    ram_rd_addr = nxt_idx[AW-1:0];
                    n_idx       = nxt_idx[AW-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_res_st;
                    n_out.node_index   = OUT_IDX_W'(r_res_idx);
                    n_out.stored_count = OUT_IDX_W'(r_count);
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("stored count above node total");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_idx <= LAST_NODE)
        else $error("walk index outside node ram");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && ram_we) |=> r_count == $past(r_count) + AW'(1))
        else $error("insert did not bump stored count");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside hand-off");

    a_no_clear_write_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result present during clearing pass");

endmodule
